[rtl/counter_based_hash_rng_top_assert.svh]
// Assertion macros for the counter-based hash generator.
// Included by the top level; expects nothing but a clock and reset in scope.
`ifndef COUNTER_BASED_HASH_RNG_TOP_ASSERT_SVH
`define COUNTER_BASED_HASH_RNG_TOP_ASSERT_SVH

// same-cycle implication
`define CBHR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBHR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cbhr_pkg.sv]
// Package for the counter-based hash generator: transfer types and mixer constants.
// No dependencies.
`timescale 1ns / 1ps

package cbhr_pkg;

  localparam logic [63:0] GOLDEN_GAMMA  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A     = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B     = 64'h94d049bb133111eb;
  localparam logic [63:0] ENTITY_OFFSET = 64'h00000100000001b3;
  localparam logic [63:0] TICK_OFFSET   = 64'h000000009e3779b9;
  localparam logic [63:0] SAMPLE_OFFSET = 64'hd6e8feb86659fd93;

  // offset and the mixer's own gamma folded into one addend
  localparam logic [63:0] ENTITY_BIAS = ENTITY_OFFSET + GOLDEN_GAMMA;
  localparam logic [63:0] TICK_BIAS   = TICK_OFFSET + GOLDEN_GAMMA;
  localparam logic [63:0] SAMPLE_BIAS = SAMPLE_OFFSET + GOLDEN_GAMMA;

  localparam int SHIFT_A        = 30;
  localparam int SHIFT_B        = 27;
  localparam int SHIFT_C        = 31;
  localparam int FRACTION_SHIFT = 11;
  localparam int FRACTION_BITS  = 53;

  typedef struct packed {
    logic [63:0]        entity_id;
    logic [63:0]        tick_count;
    logic [7:0]         domain_code;
    logic [63:0]        sample_index;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } in_item_t;

  typedef struct packed {
    logic [63:0]              hash_word;
    logic [FRACTION_BITS-1:0] unit_fraction;
    logic signed [31:0]       scaled_value;
  } out_item_t;

  // stage loads for one mixer
  typedef struct packed {
    logic pp_a;
    logic sum_a;
    logic pp_b;
    logic sum_b;
  } mix_en_t;

  // range data carried alongside the hash
  typedef struct packed {
    logic signed [31:0] lo;
    logic               neg;
    logic [32:0]        mag;
  } side_t;

endpackage

[rtl/counter_based_hash_rng_top.sv]
// Counter-based hash generator: one result per transfer, fourteen-stage pipeline.
// One transfer is taken every cycle while in_stall is low. The depth is set by
// the two chained splitmix64 mixers, whose 64-bit multiplies each take a
// partial-product stage and a sum stage, by bias, combine and hash-word stages
// and by three stages of range scaling. A stalled result holds only the stages
// behind it that are full, so empty stages keep filling. The seed is written
// through cfg_wr_en and applies to transfers accepted afterwards. Depends on
// cbhr_pkg, cbhr_mix and the assertion header.
`timescale 1ns / 1ps

module counter_based_hash_rng_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [63:0]         cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  cbhr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output cbhr_pkg::out_item_t out_item
);

  `include "counter_based_hash_rng_top_assert.svh"

  logic [63:0]          seed_r;
  logic [13:0]          v_r;
  logic [14:0]          rdy;

  logic [63:0]          t_r [0:4];
  logic signed [31:0]   lo0_r;
  logic signed [32:0]   diff0_r;
  logic signed [32:0]   diff_nxt;
  cbhr_pkg::side_t      side_nxt;
  cbhr_pkg::side_t      side_r [1:12];

  cbhr_pkg::mix_en_t    en_first;
  cbhr_pkg::mix_en_t    en_second;
  logic [63:0]          z1 [0:4];
  logic [63:0]          z2;
  logic [63:0]          comb_nxt;
  logic [63:0]          comb_r;
  logic [63:0]          h10_r;
  logic [63:0]          h11_r;
  logic [63:0]          h12_r;

  logic [cbhr_pkg::FRACTION_BITS-1:0] frac10;
  logic [63:0]          plo_nxt;
  logic [52:0]          phi_nxt;
  logic [63:0]          plo_r;
  logic [52:0]          phi_r;
  logic [52:0]          t12;
  logic [31:0]          q_r;
  logic                 rem_r;
  logic signed [31:0]   scaled_nxt;
  cbhr_pkg::out_item_t  out_r;

  // stage k loads when empty or when the stage after it moves on
  always_comb begin
    rdy[14] = !out_stall;
    for (int k = 13; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0] || !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      v_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < 14; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 0: bias the five words and take the range difference
  assign diff_nxt = 33'(in_item.range_high) - 33'(in_item.range_low);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      t_r[0]  <= seed_r + cbhr_pkg::GOLDEN_GAMMA;
      t_r[1]  <= in_item.entity_id + cbhr_pkg::ENTITY_BIAS;
      t_r[2]  <= in_item.tick_count + cbhr_pkg::TICK_BIAS;
      t_r[3]  <= {56'h0, in_item.domain_code} + cbhr_pkg::GOLDEN_GAMMA;
      t_r[4]  <= in_item.sample_index + cbhr_pkg::SAMPLE_BIAS;
      lo0_r   <= in_item.range_low;
      diff0_r <= diff_nxt;
    end
  end

  // stage 1: sign and magnitude of the range
  always_comb begin
    side_nxt.lo  = lo0_r;
    side_nxt.neg = diff0_r[32];
    side_nxt.mag = diff0_r[32] ? 33'(-diff0_r) : 33'(diff0_r);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      side_r[1] <= side_nxt;
    end
    for (int k = 2; k < 13; k++) begin
      if (rdy[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // stages 1 to 4: five mixers in parallel
  assign en_first.pp_a  = rdy[1];
  assign en_first.sum_a = rdy[2];
  assign en_first.pp_b  = rdy[3];
  assign en_first.sum_b = rdy[4];

  for (genvar g = 0; g < 5; g++) begin : g_mix
    cbhr_mix u_mix (
      .clk (clk),
      .en  (en_first),
      .v_i (t_r[g]),
      .z_o (z1[g])
    );
  end

  // stage 5: combine and bias for the final mix
  always_comb begin
    comb_nxt = '0;
    for (int i = 0; i < 5; i++) begin
      comb_nxt = comb_nxt ^ (z1[i] ^ (z1[i] >> cbhr_pkg::SHIFT_C));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      comb_r <= comb_nxt + cbhr_pkg::GOLDEN_GAMMA;
    end
  end

  // stages 6 to 9: final mix
  assign en_second.pp_a  = rdy[6];
  assign en_second.sum_a = rdy[7];
  assign en_second.pp_b  = rdy[8];
  assign en_second.sum_b = rdy[9];

  cbhr_mix u_mix_final (
    .clk (clk),
    .en  (en_second),
    .v_i (comb_r),
    .z_o (z2)
  );

  // stage 10: hash word; stage 11: partial products of range by fraction
  assign frac10  = h10_r[63:cbhr_pkg::FRACTION_SHIFT];
  assign plo_nxt = side_r[10].mag * frac10[31:0];
  assign phi_nxt = side_r[10].mag * frac10[52:32];

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      h10_r <= z2 ^ (z2 >> cbhr_pkg::SHIFT_C);
    end
    if (rdy[11]) begin
      h11_r <= h10_r;
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
  end

  // stage 12: quotient and remainder flag; stage 13: output register
  assign t12 = phi_r + 53'(plo_r[63:32]);

  always_ff @(posedge clk) begin
    if (rdy[12]) begin
      h12_r <= h11_r;
      q_r   <= t12[52:21];
      rem_r <= (t12[20:0] != 21'h0) || (plo_r[31:0] != 32'h0);
    end
  end

  assign scaled_nxt = side_r[12].neg
                    ? side_r[12].lo - $signed(q_r) - $signed({31'h0, rem_r})
                    : side_r[12].lo + $signed(q_r);

  always_ff @(posedge clk) begin
    if (rdy[13]) begin
      out_r.hash_word     <= h12_r;
      out_r.unit_fraction <= h12_r[63:cbhr_pkg::FRACTION_SHIFT];
      out_r.scaled_value  <= scaled_nxt;
    end
  end

  assign out_valid = v_r[13];
  assign out_item  = out_r;

  `CBHR_ASSERT_IMP(a_stall_full, clk, rst_n, in_stall, v_r[0], "input stalled with stage 0 empty")
  `CBHR_ASSERT_IMP(a_free_flow, clk, rst_n, !out_stall, !in_stall, "input stalled while output flows")
  `CBHR_ASSERT_NXT(a_take, clk, rst_n, in_valid && !in_stall, v_r[0], "accepted transfer lost at entry")
  `CBHR_ASSERT_NXT(a_drain, clk, rst_n, out_valid && !out_stall && !v_r[12], !out_valid, "result repeated")

endmodule

[rtl/cbhr_mix.sv]
// Four-stage splitmix64 core: two 64-bit modular multiplies, each split into
// 32-bit partial products and a sum stage. Depends on cbhr_pkg.
`timescale 1ns / 1ps

module cbhr_mix (
  input  logic              clk,
  input  cbhr_pkg::mix_en_t en,
  input  logic [63:0]       v_i,
  output logic [63:0]       z_o
);

  logic [63:0] xa;
  logic [63:0] ll_a_nxt;
  logic [31:0] hl_a_nxt;
  logic [31:0] lh_a_nxt;
  logic [63:0] ll_a_r;
  logic [31:0] hl_a_r;
  logic [31:0] lh_a_r;
  logic [31:0] cross_a;
  logic [63:0] y_nxt;
  logic [63:0] y_r;

  logic [63:0] xb;
  logic [63:0] ll_b_nxt;
  logic [31:0] hl_b_nxt;
  logic [31:0] lh_b_nxt;
  logic [63:0] ll_b_r;
  logic [31:0] hl_b_r;
  logic [31:0] lh_b_r;
  logic [31:0] cross_b;
  logic [63:0] z_nxt;
  logic [63:0] z_r;

  assign xa       = v_i ^ (v_i >> cbhr_pkg::SHIFT_A);
  assign ll_a_nxt = xa[31:0] * cbhr_pkg::MIX_MUL_A[31:0];
  assign hl_a_nxt = xa[63:32] * cbhr_pkg::MIX_MUL_A[31:0];
  assign lh_a_nxt = xa[31:0] * cbhr_pkg::MIX_MUL_A[63:32];
  assign cross_a  = hl_a_r + lh_a_r;
  assign y_nxt    = ll_a_r + {cross_a, 32'h0};

  assign xb       = y_r ^ (y_r >> cbhr_pkg::SHIFT_B);
  assign ll_b_nxt = xb[31:0] * cbhr_pkg::MIX_MUL_B[31:0];
  assign hl_b_nxt = xb[63:32] * cbhr_pkg::MIX_MUL_B[31:0];
  assign lh_b_nxt = xb[31:0] * cbhr_pkg::MIX_MUL_B[63:32];
  assign cross_b  = hl_b_r + lh_b_r;
  assign z_nxt    = ll_b_r + {cross_b, 32'h0};

  always_ff @(posedge clk) begin
    if (en.pp_a) begin
      ll_a_r <= ll_a_nxt;
      hl_a_r <= hl_a_nxt;
      lh_a_r <= lh_a_nxt;
    end
    if (en.sum_a) begin
      y_r <= y_nxt;
    end
    if (en.pp_b) begin
      ll_b_r <= ll_b_nxt;
      hl_b_r <= hl_b_nxt;
      lh_b_r <= lh_b_nxt;
    end
    if (en.sum_b) begin
      z_r <= z_nxt;
    end
  end

  assign z_o = z_r;

endmodule
